[hw/rtl/srev_pkg.sv]
// Shared constants and controller-to-datapath types for the stream group reverser.
package srev_pkg;

	localparam int MAX_GROUP = 16;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = $clog2(MAX_GROUP);
	localparam int CNT_W     = $clog2(MAX_GROUP + 1);
	localparam int GS_W      = 5;
	localparam logic [GS_W-1:0] GS_RESET = GS_W'(2);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             rd_last;
	} srev_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;
	} srev_sts_t;

endpackage

[hw/rtl/stream_group_reverser.sv]
// Top level of the stream group reverser: controller plus buffer datapath.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata = value[31:0], s_tlast = end_of_sequence
//  m_      | out | m_tvalid / m_tready  | m_tdata = out_value[31:0], m_tlast = out_last
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data = group_size[4:0]
//
// An input transfer is written into the group buffer RAM.
// A completed group (or a sequence end) drains n results; a new registered RAM read issues
// only once the previous one has reached the single output register and that slot frees.
// No input is accepted during a drain; a stalled m_tready holds the drain.
// arst_n clears the fill count, the sequencer and sets group size to 2.
module stream_group_reverser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srev_pkg::GS_W-1:0]     cfg_data,   // group_size[4:0]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [srev_pkg::DATA_W-1:0]   s_tdata,    // value[31:0]
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [srev_pkg::DATA_W-1:0]   m_tdata,    // out_value[31:0]
	output logic                          m_tlast
);
	import srev_pkg::*;

	srev_cmd_t cmd;
	srev_sts_t sts;

	srev_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.cmd      (cmd),
		.sts      (sts)
	);

	srev_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

[hw/rtl/srev_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module srev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Register read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hw/rtl/srev_dp.sv]
// Datapath: group buffer RAM and output register of the stream group reverser.
module srev_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  srev_pkg::srev_cmd_t       cmd,
	output srev_pkg::srev_sts_t       sts,
	input  logic [srev_pkg::DATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [srev_pkg::DATA_W-1:0] m_tdata,
	output logic                      m_tlast
);
	import srev_pkg::*;

	logic [DATA_W-1:0] rd_data;
	logic              pend_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;

	srev_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_GROUP)
	) u_buf (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(cmd.wr_addr),
		.wr_data(s_tdata),
		.rd_en  (cmd.rd_en),
		.rd_addr(cmd.rd_addr),
		.rd_data(rd_data)
	);

	// Track a read in flight and its last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			pend_s1 <= cmd.rd_en;
			last_s1 <= cmd.rd_last;
		end
	end

	// Load the output register when read data arrives, drop it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			out_data_q <= rd_data;
			out_last_q <= last_s1;
		end
	end

	// A read may issue only when nothing is in flight and the slot frees up
	assign sts.out_free = !pend_s1 && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

[hw/rtl/srev_ctrl.sv]
// Controller: fill count, group size register and drain sequencer.
module srev_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srev_pkg::GS_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          s_tlast,
	output srev_pkg::srev_cmd_t           cmd,
	input  srev_pkg::srev_sts_t           sts
);
	import srev_pkg::*;

	typedef enum logic [0:0] {
		ST_FILL,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic [GS_W-1:0]  group_size_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] left_q;
	logic [IDX_W-1:0] idx_q;
	logic             rev_q;
	logic             eos_q;

	logic [CNT_W-1:0] eff_g;
	logic [CNT_W-1:0] n_new;
	logic             accept;
	logic             full;
	logic             issue;

	// Clamp the group size into one to the buffer depth
	always_comb begin
		if (group_size_q == '0) begin
			eff_g = CNT_W'(1);
		end else if (CNT_W'(group_size_q) > CNT_W'(MAX_GROUP)) begin
			eff_g = CNT_W'(MAX_GROUP);
		end else begin
			eff_g = CNT_W'(group_size_q);
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_FILL);
	assign accept    = s_tvalid && s_tready;
	assign n_new     = fill_q + CNT_W'(1);
	assign full      = (n_new >= eff_g);
	assign issue     = (state_q == ST_DRAIN) && sts.out_free;

	// Commands to the datapath
	always_comb begin
		cmd.wr_en   = accept;
		cmd.wr_addr = fill_q[IDX_W-1:0];
		cmd.rd_en   = issue;
		cmd.rd_addr = idx_q;
		cmd.rd_last = eos_q && (left_q == CNT_W'(1));
	end

	// Hold state, count, and sequence the drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			group_size_q <= GS_RESET;
			fill_q       <= '0;
			left_q       <= '0;
			idx_q        <= '0;
			rev_q        <= 1'b0;
			eos_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				group_size_q <= cfg_data;
			end
			case (state_q)
				ST_FILL: begin
					if (accept) begin
						if (full || s_tlast) begin
							state_q <= ST_DRAIN;
							fill_q  <= '0;
							left_q  <= n_new;
							rev_q   <= full;
							eos_q   <= s_tlast;
							idx_q   <= full ? fill_q[IDX_W-1:0] : '0;
						end else begin
							fill_q <= n_new;
						end
					end
				end
				ST_DRAIN: begin
					if (issue) begin
						left_q <= left_q - CNT_W'(1);
						idx_q  <= rev_q ? idx_q - IDX_W'(1) : idx_q + IDX_W'(1);
						if (left_q == CNT_W'(1)) begin
							state_q <= ST_FILL;
						end
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

endmodule
